[sv/kmsd_pkg.sv]
package kmsd_pkg;

   localparam int ROWS_DEFAULT       = 4;
   localparam int COLUMNS_DEFAULT    = 4;
   localparam int FIFO_DEPTH_DEFAULT = 2;

   localparam int TIME_W     = 32;
   localparam int COLS_W     = 4;
   localparam int QUERY_W    = 8;
   localparam int ROW_OUT_W  = 2;
   localparam int KEY_OUT_W  = 4;
   localparam int CNT_W      = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] LOCKOUT_RESET = 16'd10;
   localparam logic [0:0]       REG_LOCKOUT   = 1'b0;

   typedef struct packed {
      logic               tick;
      logic               read;
      logic [COLS_W-1:0]  column_bits;
      logic [QUERY_W-1:0] query_key;
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

endpackage

[sv/kmsd_req_if.sv]
interface kmsd_req_if import kmsd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TIME_W-1:0]  time_now;
   logic [COLS_W-1:0]  column_bits;
   logic [QUERY_W-1:0] query_key;

   modport source (output valid, time_now, column_bits, query_key, input ready);
   modport sink (input valid, time_now, column_bits, query_key, output ready);
endinterface

[sv/kmsd_rsp_if.sv]
interface kmsd_rsp_if import kmsd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ROW_OUT_W-1:0] row_drive;
   logic                 event_valid;
   logic [KEY_OUT_W-1:0] event_key;
   logic                 event_down;
   logic                 query_ok;
   logic                 query_down;
   logic                 last_result;

   modport source (output valid, row_drive, event_valid, event_key, event_down,
                   query_ok, query_down, last_result, input ready);
   modport sink (input valid, row_drive, event_valid, event_key, event_down,
                 query_ok, query_down, last_result, output ready);
endinterface

[sv/kmsd_front.sv]
module kmsd_front import kmsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   kmsd_req_if.sink    req,
   input  logic        fifo_full,
   output logic        push,
   output cmd_type     push_cmd
);

   logic [TIME_W-1:0] prev_time_ff, prev_time_in;
   logic              read_phase_ff, read_phase_in;

   assign req.ready = !fifo_full;
   assign push      = req.valid && !fifo_full;

   always_comb begin
      push_cmd.tick        = req.time_now != prev_time_ff;
      push_cmd.read        = read_phase_ff;
      push_cmd.column_bits = req.column_bits;
      push_cmd.query_key   = req.query_key;
      prev_time_in         = push ? req.time_now : prev_time_ff;
      read_phase_in        = push ? !read_phase_ff : read_phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff  <= '0;
         read_phase_ff <= 1'b0;
      end else begin
         prev_time_ff  <= prev_time_in;
         read_phase_ff <= read_phase_in;
      end
   end

endmodule

[sv/kmsd_fifo.sv]
module kmsd_fifo import kmsd_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W_F = $clog2(DEPTH + 1);

   cmd_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_F-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = count_ff == CNT_W_F'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/kmsd_back.sv]
module kmsd_back import kmsd_pkg::*; #(
   parameter int ROWS    = ROWS_DEFAULT,
   parameter int COLUMNS = COLUMNS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fifo_empty,
   input  cmd_type          cmd,
   output logic             pop,
   input  logic [CNT_W-1:0] lockout_ticks,
   kmsd_rsp_if.source       rsp
);

   localparam int KEYS  = ROWS * COLUMNS;
   localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   back_state_type      state_ff, state_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CNT_W-1:0]    lock_ff [KEYS];
   logic [CNT_W-1:0]    lock_in [KEYS];
   logic [KEYS-1:0]     down_ff, down_in;
   logic [COLUMNS-1:0]  mask_ff, mask_in;
   logic                qok_ff, qok_in;
   logic                qdown_ff, qdown_in;

   logic                rsp_valid_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic                rsp_event_ff;
   logic [KEY_OUT_W-1:0] rsp_key_ff;
   logic                rsp_down_ff;
   logic                rsp_qok_ff;
   logic                rsp_qdown_ff;
   logic                rsp_last_ff;

   logic [CNT_W-1:0]    eff [KEYS];
   logic [COLUMNS-1:0]  pressed;
   logic [COLUMNS-1:0]  change;
   logic [COLUMNS-1:0]  sel_oh;
   logic [KEY_W-1:0]    sel_key;
   logic                last_pick;
   logic                slot_free;
   logic                emit;
   logic [ROW_W+1:0]    row_wide;
   logic [KEY_W+3:0]    key_wide;

   genvar gc;
   for (gc = 0; gc < COLUMNS; gc++) begin : g_col
      if (gc < COLS_W) begin : g_sampled
         assign pressed[gc] = cmd.column_bits[gc];
      end else begin : g_unsampled
         assign pressed[gc] = 1'b0;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      logic [KEY_W-1:0] key_idx;
      for (int k = 0; k < KEYS; k++) begin
         eff[k] = (cmd.tick && lock_ff[k] != '0) ? lock_ff[k] - 1'b1 : lock_ff[k];
      end
      for (int k = 0; k < KEYS; k++) begin
         lock_in[k] = eff[k];
      end
      down_in = down_ff;
      change  = '0;
      for (int c = 0; c < COLUMNS; c++) begin
         key_idx = KEY_W'(c * ROWS) + KEY_W'(row_ff);
         if (cmd.read && eff[key_idx] == '0 && pressed[c] != down_ff[key_idx]) begin
            change[c]        = 1'b1;
            lock_in[key_idx] = lockout_ticks;
            down_in[key_idx] = pressed[c];
         end
      end
      if (cmd.read) begin
         row_in = row_ff;
      end else begin
         row_in = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
      end
      qok_in   = {1'b0, cmd.query_key} < (QUERY_W + 1)'(KEYS);
      qdown_in = qok_in && down_in[cmd.query_key[KEY_W-1:0]];
   end

   always_comb begin
      sel_oh  = '0;
      sel_key = '0;
      for (int c = COLUMNS - 1; c >= 0; c--) begin
         if (mask_ff[c]) begin
            sel_oh    = '0;
            sel_oh[c] = 1'b1;
            sel_key   = KEY_W'(c * ROWS) + KEY_W'(row_ff);
         end
      end
      last_pick = (mask_ff & ~sel_oh) == '0;
      mask_in   = mask_ff & ~sel_oh;
      row_wide  = {2'b00, row_ff};
      key_wide  = {4'b0000, sel_key};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!fifo_empty) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (slot_free && last_pick) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop  = 1'b0;
      emit = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            pop = !fifo_empty;
         end
         BACK_EMIT: begin
            emit = slot_free;
         end
         default: begin
            pop  = 1'b0;
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         row_ff       <= ROW_W'(ROWS - 1);
         down_ff      <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < KEYS; k++) begin
            lock_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (pop) begin
            row_ff  <= row_in;
            down_ff <= down_in;
            mask_ff <= change;
            for (int k = 0; k < KEYS; k++) begin
               lock_ff[k] <= lock_in[k];
            end
         end else if (emit) begin
            mask_ff <= mask_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         qok_ff   <= qok_in;
         qdown_ff <= qdown_in;
      end
      if (emit) begin
         rsp_row_ff   <= row_wide[ROW_OUT_W-1:0];
         rsp_event_ff <= mask_ff != '0;
         rsp_key_ff   <= key_wide[KEY_OUT_W-1:0];
         rsp_down_ff  <= (mask_ff != '0) && down_ff[sel_key];
         rsp_qok_ff   <= qok_ff;
         rsp_qdown_ff <= qdown_ff;
         rsp_last_ff  <= last_pick;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.row_drive   = rsp_row_ff;
   assign rsp.event_valid = rsp_event_ff;
   assign rsp.event_key   = rsp_key_ff;
   assign rsp.event_down  = rsp_down_ff;
   assign rsp.query_ok    = rsp_qok_ff;
   assign rsp.query_down  = rsp_qdown_ff;
   assign rsp.last_result = rsp_last_ff;

endmodule

[sv/keypad_matrix_scan_debounce.sv]
// Keypad matrix scanner with per-key debounce lockout.
// Each transfer on the request channel is one poll: a tick value, the sampled
// column bits and a key number to query. Polls alternate between selecting the
// next row and reading the columns of the selected row. A key change in an
// unlocked key produces a press or release event and reloads its lockout
// counter from the lockout register, which sits at byte address 0 of the APB
// port. Every poll yields one result per event, in increasing column order,
// or a single result without an event; the final one has last_result set.
// A poll is taken by the front end into a command queue of FIFO_DEPTH entries
// (two by default). The back end pops a poll and updates the key state, then
// emits its results one at a time into the result register; it pops the next
// poll only after the last result of the current one is emitted. The result
// register holds while the receiver stalls; the queue keeps taking polls until
// it is full. Reset clears all key state and lockout counters, selects the
// last row and loads the lockout register with ten ticks.
module keypad_matrix_scan_debounce import kmsd_pkg::*; #(
   parameter int ROWS       = ROWS_DEFAULT,
   parameter int COLUMNS    = COLUMNS_DEFAULT,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   kmsd_req_if.sink              req_chan,
   kmsd_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CNT_W-1:0] lockout_ff, lockout_in;
   logic             push, pop, fifo_full, fifo_empty;
   cmd_type          push_cmd, pop_cmd;

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1] == REG_LOCKOUT) ?
                   {{(CSR_DATA_W - CNT_W){1'b0}}, lockout_ff} : '0;

   always_comb begin
      lockout_in = lockout_ff;
      if (psel && penable && pwrite && paddr[CSR_ADDR_W-1] == REG_LOCKOUT) begin
         lockout_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= LOCKOUT_RESET;
      end else begin
         lockout_ff <= lockout_in;
      end
   end

   kmsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .fifo_full (fifo_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   kmsd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (fifo_empty)
   );

   kmsd_back #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_empty    (fifo_empty),
      .cmd           (pop_cmd),
      .pop           (pop),
      .lockout_ticks (lockout_ff),
      .rsp           (rsp_chan)
   );

endmodule

[sv/kmsd_checker.sv]
module kmsd_checker import kmsd_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 event_valid,
   input logic [KEY_OUT_W-1:0] event_key,
   input logic                 event_down,
   input logic                 query_ok,
   input logic                 query_down,
   input logic                 last_result
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid;
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("Result withdrawn while stalled.");

   property p_reset_quiet;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_quiet: assert property (p_reset_quiet)
      else $error("Result valid right after reset.");

   property p_no_event_clean;
      @(posedge clock) disable iff (reset)
         rsp_valid && !event_valid |-> event_key == '0 && !event_down && last_result;
   endproperty
   a_no_event_clean: assert property (p_no_event_clean)
      else $error("Result without event carries event data or is not last.");

   property p_query_gate;
      @(posedge clock) disable iff (reset)
         rsp_valid && !query_ok |-> !query_down;
   endproperty
   a_query_gate: assert property (p_query_gate)
      else $error("Invalid query reports a pressed key.");

endmodule

bind keypad_matrix_scan_debounce kmsd_checker u_kmsd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .event_valid (rsp_chan.event_valid),
   .event_key   (rsp_chan.event_key),
   .event_down  (rsp_chan.event_down),
   .query_ok    (rsp_chan.query_ok),
   .query_down  (rsp_chan.query_down),
   .last_result (rsp_chan.last_result)
);
